// ===== src/rsts_pkg.sv =====
// Package for the receiver scan target sequencer: widths, constants, codes and
// the structs that pass between the top level and the list scan engine.
// No dependencies.
package rsts_pkg;

    // Channel table depth and the widths that follow from it.
    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

    // Field widths.
    localparam int FREQ_W   = 33;
    localparam int DWELL_W  = 32;
    localparam int CHAN_W   = 7;
    localparam int INDEX_W  = 6;
    localparam int LLEN_W   = 7;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 33;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    // Marine pair and dwell constants.
    localparam logic [FREQ_W-1:0]  MARINE_FREQ_A  = 33'd162000000;
    localparam logic [FREQ_W-1:0]  MARINE_FREQ_B  = 33'd156525000;
    localparam logic [DWELL_W-1:0] MARINE_DWELL   = 32'd5000;
    localparam logic [DWELL_W-1:0] FALLBACK_DWELL = 32'd500;
    localparam logic [CHAN_W-1:0]  NO_CHANNEL     = 7'h7F;

    typedef enum logic [1:0] {
        MODE_FIXED  = 2'd0,
        MODE_RANGE  = 2'd1,
        MODE_LIST   = 2'd2,
        MODE_MARINE = 2'd3
    } scan_mode_t;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_SCAN_MODE    = 3'd0,
        REG_FIXED_FREQ   = 3'd1,
        REG_RANGE_START  = 3'd2,
        REG_RANGE_END    = 3'd3,
        REG_RANGE_STEP   = 3'd4,
        REG_DEFAULT_DWELL = 3'd5,
        REG_LIST_LENGTH  = 3'd6,
        REG_LIST_REPORTS = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_WRITE   = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIST,
        ST_PUSH
    } top_state_t;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } scan_state_t;

    // Table write port.
    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [FREQ_W-1:0]     freq;
        logic [DWELL_W-1:0]    dwell;
    } tbl_wr_t;

    // Scan start request.
    typedef struct packed {
        logic                  start;
        logic [ADDR_W-1:0]     pos;
        logic [LEN_W-1:0]      len;
    } scan_req_t;

    // Scan completion report.
    typedef struct packed {
        logic                  done;
        logic                  found;
        logic [ADDR_W-1:0]     pos;
        logic [ADDR_W-1:0]     next_pos;
        logic [FREQ_W-1:0]     freq;
        logic [DWELL_W-1:0]    dwell;
    } scan_rsp_t;

    // Round-robin successor of a table position within the active length.
    function automatic logic [ADDR_W-1:0] wrap_pos(input logic [ADDR_W-1:0] pos,
                                                   input logic [LEN_W-1:0]  len);
        logic [LEN_W:0] p1;
        p1 = (LEN_W + 1)'(pos) + (LEN_W + 1)'(1);
        if (p1 >= {1'b0, len}) begin
            return '0;
        end
        return ADDR_W'(p1);
    endfunction

endpackage

// ===== src/radio_scan_target_sequencer.sv =====
// Top level of the receiver scan target sequencer: configuration registers,
// fixed, range and marine target logic, and the output register.
// Depends on rsts_pkg and rsts_list_scan.
//
// Channel  Direction  Handshake                Payload
// s_       in         s_tvalid / s_tready      s_tdata table entry, s_tuser action
// m_       out        m_tvalid / m_tready      m_tdata next target
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Fixed, range and marine targets are computed on acceptance into the pending
// result stage and moved to the output register; table writes and empty requests
// leave the sequencer idle. List requests are served by the scan engine, which
// reads one table entry a cycle from the table memory.
// Reset is synchronous and active low and leaves the table as it is. A beat is
// accepted while a result waits in the output register; the next result waits.
module radio_scan_target_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[5:0], entry_freq_hz[38:6], entry_dwell_ms[70:39], zero pad[71]
    input  logic [rsts_pkg::S_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // target_freq_hz[32:0], target_dwell_ms[64:33], channel_number[71:65]
    output logic [rsts_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsts_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [rsts_pkg::CFG_D_W-1:0]   cfg_data
);

    localparam int FW = rsts_pkg::FREQ_W;
    localparam int DW = rsts_pkg::DWELL_W;
    localparam int CW = rsts_pkg::CHAN_W;
    localparam int AW = rsts_pkg::ADDR_W;
    localparam int LW = rsts_pkg::LEN_W;

    // Input beat fields.
    logic [rsts_pkg::INDEX_W-1:0] in_index;
    logic [FW-1:0]                in_freq;
    logic [DW-1:0]                in_dwell;
    logic                         in_accept;
    logic                         cfg_accept;

    assign in_index   = s_tdata[5:0];
    assign in_freq    = s_tdata[38:6];
    assign in_dwell   = s_tdata[70:39];
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_ready  = 1'b1;

    // Configuration registers.
    rsts_pkg::scan_mode_t            mode_reg;
    logic [FW-1:0]                   fixed_freq_reg;
    logic [FW-1:0]                   range_start_reg;
    logic [FW-1:0]                   range_end_reg;
    logic [FW-1:0]                   range_step_reg;
    logic [DW-1:0]                   def_dwell_reg;
    logic [rsts_pkg::LLEN_W-1:0]     list_length_reg;
    logic                            list_reports_reg;

    // Cursors.
    logic [FW-1:0] range_next_reg, range_next_next;
    logic [AW-1:0] list_cursor_reg, list_cursor_next;
    logic          pair_cursor_reg, pair_cursor_next;

    rsts_pkg::top_state_t state_reg, state_next;

    // Pending result stage and output register.
    logic [FW-1:0] res_freq_reg, res_freq_next;
    logic [DW-1:0] res_dwell_reg, res_dwell_next;
    logic [CW-1:0] res_chan_reg, res_chan_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rsts_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    rsts_pkg::tbl_wr_t   tbl_wr;
    rsts_pkg::scan_req_t scan_req;
    rsts_pkg::scan_rsp_t scan_rsp;

    // Derived values.
    logic [DW-1:0] eff_dwell;
    logic [LW-1:0] len_eff;
    logic          entry_ok;
    logic          range_bad;
    logic [FW-1:0] range_cur;
    logic [FW:0]   range_sum;
    logic [FW-1:0] range_nxt;

    assign eff_dwell = (def_dwell_reg == '0) ? rsts_pkg::FALLBACK_DWELL : def_dwell_reg;
    assign len_eff   = (32'(list_length_reg) > rsts_pkg::LIST_DEPTH)
                     ? LW'(rsts_pkg::LIST_DEPTH) : LW'(list_length_reg);
    assign entry_ok  = (32'(in_index) < rsts_pkg::LIST_DEPTH);

    // Range step: one compare set and one add.
    assign range_bad = (range_start_reg == '0) || (range_end_reg == '0) ||
                       (range_step_reg == '0) || (range_end_reg < range_start_reg);
    assign range_cur = ((range_next_reg < range_start_reg) ||
                        (range_next_reg > range_end_reg)) ? range_start_reg : range_next_reg;
    assign range_sum = {1'b0, range_cur} + {1'b0, range_step_reg};
    assign range_nxt = (range_cur >= range_end_reg) ? range_start_reg :
                       (range_sum > {1'b0, range_end_reg}) ? range_end_reg :
                       range_sum[FW-1:0];

    assign s_tready = (state_reg == rsts_pkg::ST_IDLE);

    // Table writes go straight to the scan engine's memory.
    always_comb begin
        tbl_wr.en    = in_accept && (s_tuser == rsts_pkg::ACT_WRITE) && entry_ok;
        tbl_wr.addr  = AW'(in_index);
        tbl_wr.freq  = in_freq;
        tbl_wr.dwell = in_dwell;
    end

    rsts_list_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .req     (scan_req),
        .rsp     (scan_rsp)
    );

    // Request handling, cursor updates and result staging.
    always_comb begin
        state_next       = state_reg;
        range_next_next  = range_next_reg;
        list_cursor_next = list_cursor_reg;
        pair_cursor_next = pair_cursor_reg;
        res_freq_next    = res_freq_reg;
        res_dwell_next   = res_dwell_reg;
        res_chan_next    = res_chan_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        scan_req.start   = 1'b0;
        scan_req.pos     = (LW'(list_cursor_reg) >= len_eff) ? '0 : list_cursor_reg;
        scan_req.len     = len_eff;

        unique case (state_reg)
            rsts_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == rsts_pkg::ACT_WRITE) begin
                        if (entry_ok) begin
                            range_next_next  = range_start_reg;
                            list_cursor_next = '0;
                            pair_cursor_next = 1'b0;
                        end
                    end else begin
                        unique case (mode_reg)
                            rsts_pkg::MODE_FIXED: begin
                                if (fixed_freq_reg != '0) begin
                                    res_freq_next  = fixed_freq_reg;
                                    res_dwell_next = eff_dwell;
                                    res_chan_next  = rsts_pkg::NO_CHANNEL;
                                    state_next     = rsts_pkg::ST_PUSH;
                                end
                            end
                            rsts_pkg::MODE_RANGE: begin
                                if (!range_bad) begin
                                    res_freq_next   = range_cur;
                                    res_dwell_next  = eff_dwell;
                                    res_chan_next   = rsts_pkg::NO_CHANNEL;
                                    range_next_next = range_nxt;
                                    state_next      = rsts_pkg::ST_PUSH;
                                end
                            end
                            rsts_pkg::MODE_LIST: begin
                                if (len_eff != '0) begin
                                    scan_req.start = 1'b1;
                                    state_next     = rsts_pkg::ST_LIST;
                                end
                            end
                            rsts_pkg::MODE_MARINE: begin
                                res_freq_next    = pair_cursor_reg ? rsts_pkg::MARINE_FREQ_B
                                                                   : rsts_pkg::MARINE_FREQ_A;
                                res_dwell_next   = rsts_pkg::MARINE_DWELL;
                                res_chan_next    = rsts_pkg::NO_CHANNEL;
                                pair_cursor_next = !pair_cursor_reg;
                                state_next       = rsts_pkg::ST_PUSH;
                            end
                            default: begin
                                state_next = rsts_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            rsts_pkg::ST_LIST: begin
                if (scan_rsp.done) begin
                    if (scan_rsp.found) begin
                        list_cursor_next = scan_rsp.next_pos;
                        res_freq_next    = scan_rsp.freq;
                        if (list_reports_reg) begin
                            res_dwell_next = (scan_rsp.dwell != '0) ? scan_rsp.dwell
                                                                    : eff_dwell;
                            res_chan_next  = CW'(scan_rsp.pos);
                        end else begin
                            res_dwell_next = eff_dwell;
                            res_chan_next  = rsts_pkg::NO_CHANNEL;
                        end
                        state_next = rsts_pkg::ST_PUSH;
                    end else begin
                        state_next = rsts_pkg::ST_IDLE;
                    end
                end
            end
            rsts_pkg::ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_chan_reg, res_dwell_reg, res_freq_reg};
                    state_next    = rsts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsts_pkg::ST_IDLE;
            end
        endcase

        // A register write restarts every cursor from the new settings.
        if (cfg_accept) begin
            range_next_next  = (cfg_index == rsts_pkg::REG_RANGE_START)
                             ? cfg_data[FW-1:0] : range_start_reg;
            list_cursor_next = '0;
            pair_cursor_next = 1'b0;
        end
    end

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= rsts_pkg::MODE_FIXED;
            fixed_freq_reg   <= '0;
            range_start_reg  <= '0;
            range_end_reg    <= '0;
            range_step_reg   <= '0;
            def_dwell_reg    <= '0;
            list_length_reg  <= '0;
            list_reports_reg <= 1'b1;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                rsts_pkg::REG_SCAN_MODE:     mode_reg <= rsts_pkg::scan_mode_t'(cfg_data[1:0]);
                rsts_pkg::REG_FIXED_FREQ:    fixed_freq_reg   <= cfg_data[FW-1:0];
                rsts_pkg::REG_RANGE_START:   range_start_reg  <= cfg_data[FW-1:0];
                rsts_pkg::REG_RANGE_END:     range_end_reg    <= cfg_data[FW-1:0];
                rsts_pkg::REG_RANGE_STEP:    range_step_reg   <= cfg_data[FW-1:0];
                rsts_pkg::REG_DEFAULT_DWELL: def_dwell_reg    <= cfg_data[DW-1:0];
                rsts_pkg::REG_LIST_LENGTH:   list_length_reg  <= cfg_data[rsts_pkg::LLEN_W-1:0];
                rsts_pkg::REG_LIST_REPORTS:  list_reports_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control state and cursors.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rsts_pkg::ST_IDLE;
            range_next_reg  <= '0;
            list_cursor_reg <= '0;
            pair_cursor_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            range_next_reg  <= range_next_next;
            list_cursor_reg <= list_cursor_next;
            pair_cursor_reg <= pair_cursor_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        res_freq_reg  <= res_freq_next;
        res_dwell_reg <= res_dwell_next;
        res_chan_reg  <= res_chan_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A staged result reaches the output register once it is free.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsts_pkg::ST_PUSH && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("staged result did not reach the output register");

    // The scan engine reports only while a list request is open.
    a_rsp_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_rsp.done |-> (state_reg == rsts_pkg::ST_LIST))
        else $error("scan report outside a list request");

    // Every target handed out has a nonzero frequency.
    a_out_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[FW-1:0] != '0))
        else $error("target beat with zero frequency");

endmodule

// ===== src/rsts_list_scan.sv =====
// Channel table memory and the round-robin scan engine that searches it for
// the next entry with a nonzero frequency. Depends on rsts_pkg.
module rsts_list_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsts_pkg::tbl_wr_t   wr,
    input  rsts_pkg::scan_req_t req,
    output rsts_pkg::scan_rsp_t rsp
);

    localparam int WORD_W = rsts_pkg::FREQ_W + rsts_pkg::DWELL_W;

    // Table memory: frequency in the upper bits, dwell in the lower bits.
    logic [WORD_W-1:0] table_mem [rsts_pkg::LIST_DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    rsts_pkg::scan_state_t          state_reg, state_next;
    logic [rsts_pkg::ADDR_W-1:0]    iss_pos_reg, iss_pos_next;
    logic [rsts_pkg::ADDR_W-1:0]    chk_pos_reg, chk_pos_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [rsts_pkg::LEN_W-1:0]     chk_cnt_reg, chk_cnt_next;
    logic [rsts_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                           hit;

    // One write and one registered read a cycle. Writes only come while the
    // engine is idle, so a read used by a scan never meets a write to the same entry.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            table_mem[wr.addr] <= {wr.freq, wr.dwell};
        end
        rd_word_reg <= table_mem[iss_pos_reg];
    end

    assign hit = (rd_word_reg[WORD_W-1:rsts_pkg::DWELL_W] != '0);

    // Reads are issued one entry a cycle; each is checked in the cycle after its issue.
    always_comb begin
        state_next   = state_reg;
        iss_pos_next = iss_pos_reg;
        chk_pos_next = chk_pos_reg;
        chk_vld_next = chk_vld_reg;
        chk_cnt_next = chk_cnt_reg;
        len_next     = len_reg;

        rsp.done     = 1'b0;
        rsp.found    = hit;
        rsp.pos      = chk_pos_reg;
        rsp.next_pos = rsts_pkg::wrap_pos(chk_pos_reg, len_reg);
        rsp.freq     = rd_word_reg[WORD_W-1:rsts_pkg::DWELL_W];
        rsp.dwell    = rd_word_reg[rsts_pkg::DWELL_W-1:0];

        unique case (state_reg)
            rsts_pkg::SC_IDLE: begin
                if (req.start) begin
                    state_next   = rsts_pkg::SC_RUN;
                    iss_pos_next = req.pos;
                    chk_vld_next = 1'b0;
                    chk_cnt_next = '0;
                    len_next     = req.len;
                end
            end
            rsts_pkg::SC_RUN: begin
                iss_pos_next = rsts_pkg::wrap_pos(iss_pos_reg, len_reg);
                chk_pos_next = iss_pos_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg) begin
                    if (hit) begin
                        rsp.done   = 1'b1;
                        state_next = rsts_pkg::SC_IDLE;
                    end else if (chk_cnt_reg == len_reg - rsts_pkg::LEN_W'(1)) begin
                        // Every active entry was checked and none was live.
                        rsp.done   = 1'b1;
                        state_next = rsts_pkg::SC_IDLE;
                    end else begin
                        chk_cnt_next = chk_cnt_reg + rsts_pkg::LEN_W'(1);
                    end
                end
            end
            default: begin
                state_next = rsts_pkg::SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsts_pkg::SC_IDLE;
            chk_vld_reg <= 1'b0;
            chk_cnt_reg <= '0;
            len_reg     <= '0;
            iss_pos_reg <= '0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            chk_cnt_reg <= chk_cnt_next;
            len_reg     <= len_next;
            iss_pos_reg <= iss_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_pos_reg <= chk_pos_next;
    end

    // A reported hit always carries a live frequency.
    a_hit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && rsp.found) |-> (rsp.freq != '0))
        else $error("scan reported a hit on a zero frequency entry");

    // The check count never reaches the active length while running.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsts_pkg::SC_RUN) |-> (chk_cnt_reg < len_reg))
        else $error("scan check count ran past the active length");

endmodule
